FILE: src/dfhe_pkg.sv
package dfhe_pkg;

  // Token function codes
  typedef enum logic [1:0] {
    FUNC_LITERAL = 2'd0,
    FUNC_MATCH   = 2'd1,
    FUNC_BEGIN   = 2'd2,
    FUNC_FLUSH   = 2'd3
  } func_t;

  // Kind of work handed from front to back
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_BAD   = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_t;

  localparam int CODE_BITS  = 31;  // widest code group of one token
  localparam int CODE_NBITS = 6;
  localparam int ACC_BITS   = 38;  // seven carry bits plus one code group

  // One queued token: LSB-first bit group ready for packing
  typedef struct packed {
    kind_t                   kind;
    logic [CODE_BITS-1:0]    bits;
    logic [CODE_NBITS-1:0]   nbits;
  } entry_t;

  // Fixed Huffman code bases
  localparam logic [7:0] LIT_LO_CODE  = 8'h30;
  localparam logic [8:0] LIT_HI_CODE  = 9'h190;
  localparam logic [7:0] LIT_HI_FIRST = 8'd144;
  localparam logic [7:0] LEN_HI_CODE  = 8'hc0;
  localparam logic [4:0] LEN_HI_FIRST = 5'd23;  // length index of symbol 280

  // Begin-block header: BFINAL = 1, BTYPE = 01, LSB first
  localparam logic [2:0] HDR_BITS  = 3'b011;
  localparam logic [3:0] HDR_NBITS = 4'd3;
  localparam logic [5:0] EOB_NBITS = 6'd7;

  localparam logic [8:0] LEN_MIN  = 9'd3;
  localparam logic [8:0] LEN_MAX  = 9'd258;
  localparam logic [15:0] DST_MAX = 16'd32768;

  localparam logic [8:0] LEN_BASE [29] = '{
    9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
    9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
    9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258};
  localparam logic [2:0] LEN_XBITS [29] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd0};
  localparam logic [14:0] DST_BASE [30] = '{
    15'd1, 15'd2, 15'd3, 15'd4, 15'd5, 15'd7, 15'd9, 15'd13, 15'd17, 15'd25,
    15'd33, 15'd49, 15'd65, 15'd97, 15'd129, 15'd193, 15'd257, 15'd385, 15'd513,
    15'd769, 15'd1025, 15'd1537, 15'd2049, 15'd3073, 15'd4097, 15'd6145,
    15'd8193, 15'd12289, 15'd16385, 15'd24577};
  localparam logic [3:0] DST_XBITS [30] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
    4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13};

  // Highest length code whose base does not exceed len
  function automatic logic [4:0] len_index(input logic [8:0] len);
    logic [4:0] idx;
    idx = '0;
    for (int k = 0; k < 29; k++) begin
      if (len >= LEN_BASE[k]) idx = 5'(k);
    end
    return idx;
  endfunction

  // Highest distance code whose base does not exceed the distance
  function automatic logic [4:0] dist_index(input logic [15:0] distance);
    logic [4:0] idx;
    idx = '0;
    for (int k = 0; k < 30; k++) begin
      if (distance >= {1'b0, DST_BASE[k]}) idx = 5'(k);
    end
    return idx;
  endfunction

  function automatic logic [4:0] rev5(input logic [4:0] x);
    logic [4:0] r;
    for (int i = 0; i < 5; i++) r[i] = x[4-i];
    return r;
  endfunction

  function automatic logic [6:0] rev7(input logic [6:0] x);
    logic [6:0] r;
    for (int i = 0; i < 7; i++) r[i] = x[6-i];
    return r;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] x);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = x[7-i];
    return r;
  endfunction

  function automatic logic [8:0] rev9(input logic [8:0] x);
    logic [8:0] r;
    for (int i = 0; i < 9; i++) r[i] = x[8-i];
    return r;
  endfunction

endpackage

FILE: src/dfhe_token_if.sv
interface dfhe_token_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  literal_byte;
  logic [8:0]  match_length;
  logic [15:0] match_distance;

  modport source (
    output valid, func, literal_byte, match_length, match_distance,
    input  ready
  );
  modport sink (
    input  valid, func, literal_byte, match_length, match_distance,
    output ready
  );
endinterface

FILE: src/dfhe_byte_if.sv
interface dfhe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       bad_input;

  modport source (
    output valid, out_byte, last, bad_input,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last, bad_input,
    output ready
  );
endinterface

FILE: src/dfhe_queue.sv
module dfhe_queue (
  input  logic              clk,
  input  logic              rst,
  input  dfhe_pkg::entry_t  wr_data,
  input  logic              wr_valid,
  output logic              wr_ready,
  output dfhe_pkg::entry_t  rd_data,
  output logic              rd_valid,
  input  logic              rd_ready
);

  dfhe_pkg::entry_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Store incoming entry
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wr_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/dfhe_front.sv
module dfhe_front (
  input  logic              clk,
  input  logic              rst,
  dfhe_token_if.sink        tokens,
  output dfhe_pkg::entry_t  q_data,
  output logic              q_valid,
  input  logic              q_ready
);

  // Decode stage register
  logic                  a_valid;
  dfhe_pkg::kind_t       a_kind;
  logic [8:0]            a_sym;
  logic [3:0]            a_sym_len;
  logic [4:0]            a_lx;
  logic [2:0]            a_lx_len;
  logic [4:0]            a_dc;
  logic [2:0]            a_dc_len;
  logic [12:0]           a_dx;
  logic [3:0]            a_dx_len;

  // Decode results for the offered token
  dfhe_pkg::kind_t       d_kind;
  logic [8:0]            d_sym;
  logic [3:0]            d_sym_len;
  logic [4:0]            d_lx;
  logic [2:0]            d_lx_len;
  logic [4:0]            d_dc;
  logic [2:0]            d_dc_len;
  logic [12:0]           d_dx;
  logic [3:0]            d_dx_len;
  logic [4:0]            li;
  logic [4:0]            di;
  logic [8:0]            len_diff;
  logic [15:0]           dst_diff;
  logic                  bad;
  logic                  accept;

  // Assembly offsets
  logic [4:0]            off1;
  logic [4:0]            off2;
  logic [4:0]            off3;

  assign tokens.ready = !a_valid || q_ready;
  assign accept       = tokens.valid && tokens.ready;

  // Classify the token and look up its codes
  always_comb begin
    li       = dfhe_pkg::len_index(tokens.match_length);
    di       = dfhe_pkg::dist_index(tokens.match_distance);
    len_diff = tokens.match_length - dfhe_pkg::LEN_BASE[li];
    dst_diff = tokens.match_distance - {1'b0, dfhe_pkg::DST_BASE[di]};
    bad      = (tokens.match_length < dfhe_pkg::LEN_MIN)
            || (tokens.match_length > dfhe_pkg::LEN_MAX)
            || (tokens.match_distance == 16'd0)
            || (tokens.match_distance > dfhe_pkg::DST_MAX);

    d_kind    = dfhe_pkg::KIND_DATA;
    d_sym     = '0;
    d_sym_len = '0;
    d_lx      = '0;
    d_lx_len  = '0;
    d_dc      = '0;
    d_dc_len  = '0;
    d_dx      = '0;
    d_dx_len  = '0;

    case (dfhe_pkg::func_t'(tokens.func))
      dfhe_pkg::FUNC_LITERAL: begin
        if (tokens.literal_byte < dfhe_pkg::LIT_HI_FIRST) begin
          d_sym     = {1'b0, dfhe_pkg::rev8(dfhe_pkg::LIT_LO_CODE + tokens.literal_byte)};
          d_sym_len = 4'd8;
        end else begin
          d_sym     = dfhe_pkg::rev9(dfhe_pkg::LIT_HI_CODE + {1'b0, tokens.literal_byte}
                                     - {1'b0, dfhe_pkg::LIT_HI_FIRST});
          d_sym_len = 4'd9;
        end
      end
      dfhe_pkg::FUNC_MATCH: begin
        if (bad) begin
          d_kind = dfhe_pkg::KIND_BAD;
        end else begin
          if (li < dfhe_pkg::LEN_HI_FIRST) begin
            d_sym     = {2'b00, dfhe_pkg::rev7({2'b00, li} + 7'd1)};
            d_sym_len = 4'd7;
          end else begin
            d_sym     = {1'b0, dfhe_pkg::rev8(dfhe_pkg::LEN_HI_CODE + {3'b000, li}
                                              - {3'b000, dfhe_pkg::LEN_HI_FIRST})};
            d_sym_len = 4'd8;
          end
          d_lx     = len_diff[4:0];
          d_lx_len = dfhe_pkg::LEN_XBITS[li];
          d_dc     = dfhe_pkg::rev5(di);
          d_dc_len = 3'd5;
          d_dx     = dst_diff[12:0];
          d_dx_len = dfhe_pkg::DST_XBITS[di];
        end
      end
      dfhe_pkg::FUNC_BEGIN: begin
        d_sym     = {6'd0, dfhe_pkg::HDR_BITS};
        d_sym_len = dfhe_pkg::HDR_NBITS;
      end
      default: begin
        d_kind = dfhe_pkg::KIND_FLUSH;
      end
    endcase
  end

  // Hold decoded token until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (q_ready) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind    <= d_kind;
      a_sym     <= d_sym;
      a_sym_len <= d_sym_len;
      a_lx      <= d_lx;
      a_lx_len  <= d_lx_len;
      a_dc      <= d_dc;
      a_dc_len  <= d_dc_len;
      a_dx      <= d_dx;
      a_dx_len  <= d_dx_len;
    end
  end

  // Concatenate code fields into one LSB-first group
  always_comb begin
    off1 = {1'b0, a_sym_len};
    off2 = off1 + {2'b00, a_lx_len};
    off3 = off2 + {2'b00, a_dc_len};

    q_data.kind  = a_kind;
    q_data.bits  = dfhe_pkg::CODE_BITS'(a_sym)
                 | (dfhe_pkg::CODE_BITS'(a_lx) << off1)
                 | (dfhe_pkg::CODE_BITS'(a_dc) << off2)
                 | (dfhe_pkg::CODE_BITS'(a_dx) << off3);
    q_data.nbits = {1'b0, off3} + {2'b00, a_dx_len};
  end

  assign q_valid = a_valid;

endmodule

FILE: src/dfhe_back.sv
module dfhe_back (
  input  logic              clk,
  input  logic              rst,
  input  dfhe_pkg::entry_t  q_data,
  input  logic              q_valid,
  output logic              q_ready,
  dfhe_byte_if.source       stream
);

  // Bit accumulator: pending bits, oldest in bit 0
  logic [dfhe_pkg::ACC_BITS-1:0]   acc;
  logic [dfhe_pkg::ACC_BITS-1:0]   acc_next;
  logic [dfhe_pkg::CODE_NBITS-1:0] cnt;
  logic [dfhe_pkg::CODE_NBITS-1:0] cnt_next;
  logic                            flush_pend;
  logic                            flush_pend_next;

  // Output register
  logic                            out_valid;
  logic [7:0]                      out_byte;
  logic                            out_last;
  logic                            out_bad;

  logic                            out_free;
  logic                            emit;
  logic [7:0]                      e_byte;
  logic                            e_last;
  logic                            e_bad;
  logic [dfhe_pkg::ACC_BITS-1:0]   merged;
  logic [dfhe_pkg::CODE_NBITS-1:0] merged_n;
  logic [dfhe_pkg::CODE_NBITS-1:0] flush_n;

  assign out_free = !out_valid || stream.ready;

  // Merge, drain and flush
  always_comb begin
    merged   = acc | ({7'd0, q_data.bits} << cnt[2:0]);
    merged_n = cnt + q_data.nbits;
    flush_n  = cnt + dfhe_pkg::EOB_NBITS;

    acc_next        = acc;
    cnt_next        = cnt;
    flush_pend_next = flush_pend;
    q_ready         = 1'b0;
    emit            = 1'b0;
    e_byte          = acc[7:0];
    e_last          = 1'b0;
    e_bad           = 1'b0;

    if (out_free) begin
      if (flush_pend) begin
        emit = 1'b1;
        if (cnt <= 6'd8) begin
          e_last          = 1'b1;
          acc_next        = '0;
          cnt_next        = '0;
          flush_pend_next = 1'b0;
        end else begin
          acc_next = acc >> 8;
          cnt_next = cnt - 6'd8;
        end
      end else if (cnt >= 6'd8) begin
        emit     = 1'b1;
        acc_next = acc >> 8;
        cnt_next = cnt - 6'd8;
      end else if (q_valid) begin
        q_ready = 1'b1;
        case (q_data.kind)
          dfhe_pkg::KIND_BAD: begin
            emit   = 1'b1;
            e_byte = 8'd0;
            e_bad  = 1'b1;
          end
          dfhe_pkg::KIND_FLUSH: begin
            // end-of-block code is seven zero bits
            emit = 1'b1;
            if (flush_n <= 6'd8) begin
              e_last   = 1'b1;
              acc_next = '0;
              cnt_next = '0;
            end else begin
              acc_next        = acc >> 8;
              cnt_next        = flush_n - 6'd8;
              flush_pend_next = 1'b1;
            end
          end
          default: begin
            if (merged_n >= 6'd8) begin
              emit     = 1'b1;
              e_byte   = merged[7:0];
              acc_next = merged >> 8;
              cnt_next = merged_n - 6'd8;
            end else begin
              acc_next = merged;
              cnt_next = merged_n;
            end
          end
        endcase
      end
    end
  end

  // Update packer state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      cnt        <= '0;
      flush_pend <= 1'b0;
    end else begin
      acc        <= acc_next;
      cnt        <= cnt_next;
      flush_pend <= flush_pend_next;
    end
  end

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= e_byte;
      out_last <= e_last;
      out_bad  <= e_bad;
    end
  end

  assign stream.valid     = out_valid;
  assign stream.out_byte  = out_byte;
  assign stream.last      = out_last;
  assign stream.bad_input = out_bad;

endmodule

FILE: src/deflate_fixed_huffman_encoder_core.sv
// Tokens enter at one per cycle, while the two-entry queue has room, into that queue; the packer
// then sends one byte per cycle on the output port while the port is ready, and takes the next
// token only when fewer than eight bits are left in its carry.
// Reset (synchronous, rst high) empties the decode register, queue and output register and
// clears the bit carry, its count and any pending flush.
module deflate_fixed_huffman_encoder_core (
  input  logic        clk,
  input  logic        rst,
  dfhe_token_if.sink  tokens,
  dfhe_byte_if.source stream
);

  dfhe_pkg::entry_t fq_data;
  logic             fq_valid;
  logic             fq_ready;
  dfhe_pkg::entry_t qb_data;
  logic             qb_valid;
  logic             qb_ready;

  dfhe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .tokens  (tokens),
    .q_data  (fq_data),
    .q_valid (fq_valid),
    .q_ready (fq_ready)
  );

  dfhe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (fq_data),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .rd_data  (qb_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready)
  );

  dfhe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (qb_data),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .stream  (stream)
  );

endmodule
